/* rtl/vtyp_pkg.sv */
package vtyp_pkg;

    localparam int COORD_W = 24;
    localparam int GUARD_W = 20;
    // headroom for gain growth over both vectoring passes
    localparam int HEAD_W  = 4;
    localparam int DW      = COORD_W + GUARD_W + HEAD_W;
    localparam int ANG_W   = 26;
    localparam int OUT_W   = 25;

    localparam logic signed [ANG_W-1:0] DEG_90  = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] DEG_270 = ANG_W'(270 * 65536);
    localparam logic signed [ANG_W-1:0] DEG_360 = ANG_W'(360 * 65536);

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] yaw_deg;
        logic [OUT_W-1:0] pitch_deg;
    } t_out_item;

    typedef struct packed {
        logic signed [DW-1:0]    x;
        logic signed [DW-1:0]    y;
        logic signed [ANG_W-1:0] acc;
    } t_vec;

    typedef struct packed {
        logic zero_xy;
        logic z_pos;
        logic z_neg;
    } t_side;

    // atan(2^-i) in degrees, Q16, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = ANG_W'(2949120);
            5'd1:    v = ANG_W'(1740967);
            5'd2:    v = ANG_W'(919879);
            5'd3:    v = ANG_W'(466945);
            5'd4:    v = ANG_W'(234379);
            5'd5:    v = ANG_W'(117304);
            5'd6:    v = ANG_W'(58666);
            5'd7:    v = ANG_W'(29335);
            5'd8:    v = ANG_W'(14668);
            5'd9:    v = ANG_W'(7334);
            5'd10:   v = ANG_W'(3667);
            5'd11:   v = ANG_W'(1833);
            5'd12:   v = ANG_W'(917);
            5'd13:   v = ANG_W'(458);
            5'd14:   v = ANG_W'(229);
            5'd15:   v = ANG_W'(115);
            5'd16:   v = ANG_W'(57);
            5'd17:   v = ANG_W'(29);
            5'd18:   v = ANG_W'(14);
            5'd19:   v = ANG_W'(7);
            5'd20:   v = ANG_W'(4);
            5'd21:   v = ANG_W'(2);
            5'd22:   v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // fold into [0,360); anything still outside drops to zero
    function automatic logic [OUT_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] t;
        t = a;
        if (t < 0) begin
            t = t + DEG_360;
        end
        if (t >= DEG_360 || t < 0) begin
            t = '0;
        end
        return t[OUT_W-1:0];
    endfunction

endpackage

/* rtl/vector_to_yaw_pitch_top.sv */
// Channel  Direction  Handshake                Payload
// in       input      i_in_valid / o_in_stall  i_in_data  (coord_x, coord_y, coord_z)
// out      output     o_out_valid / i_out_stall o_out_data (yaw_deg, pitch_deg)
//
// The pipeline has one prep stage, CORDIC_STEPS cells for yaw and z gain scaling side
// by side, one hand-over stage, CORDIC_STEPS cells for pitch, and the output register.
// One item enters every cycle unless stalled; each cell does one micro-rotation.
// Synchronous active-low reset clears only the stage valid bits.
// Each stage takes a new item when empty or when its neighbor downstream moves, so
// bubbles collapse and a stalled result blocks input only once every stage is full.
module vector_to_yaw_pitch_top #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  vtyp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output vtyp_pkg::t_out_item o_out_data
);

    localparam int N      = CORDIC_STEPS;
    localparam int NSTAGE = 2 * N + 3;
    localparam int S_MID  = N + 1;
    localparam int S_OUT  = 2 * N + 2;
    localparam int DW     = vtyp_pkg::DW;
    localparam int ANG_W  = vtyp_pkg::ANG_W;
    localparam int CW     = vtyp_pkg::COORD_W;
    localparam int GW     = vtyp_pkg::GUARD_W;
    localparam int EXT_W  = vtyp_pkg::HEAD_W;

    // ---------------- stage flow control ----------------
    logic [NSTAGE-1:0] w_valid;
    logic [NSTAGE:0]   w_ready;
    logic [NSTAGE-1:0] w_vin;

    assign w_vin[0]        = i_in_valid;
    assign w_ready[NSTAGE] = !i_out_stall;

    genvar k;
    generate
        for (k = 0; k < NSTAGE; k++) begin : g_link
            vtyp_link u_link (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_valid      (w_vin[k]),
                .i_ready_next (w_ready[k+1]),
                .o_valid      (w_valid[k]),
                .o_ready      (w_ready[k])
            );
            if (k < NSTAGE - 1) begin : g_fwd
                assign w_vin[k+1] = w_valid[k];
            end
        end
    endgenerate

    assign o_in_stall  = !w_ready[0];
    assign o_out_valid = w_valid[NSTAGE-1];

    // ---------------- prep stage ----------------
    logic signed [DW-1:0] w_cx;
    logic signed [DW-1:0] w_cy;
    logic signed [DW-1:0] w_cz;
    vtyp_pkg::t_vec       n_s0_yaw;
    vtyp_pkg::t_vec       n_s0_z;
    vtyp_pkg::t_side      n_s0_side;
    vtyp_pkg::t_vec       r_s0_yaw;
    vtyp_pkg::t_vec       r_s0_z;

    // scale coordinates up by the guard bits
    assign w_cx = {{EXT_W{i_in_data.coord_x[CW-1]}}, i_in_data.coord_x, {GW{1'b0}}};
    assign w_cy = {{EXT_W{i_in_data.coord_y[CW-1]}}, i_in_data.coord_y, {GW{1'b0}}};
    assign w_cz = {{EXT_W{i_in_data.coord_z[CW-1]}}, i_in_data.coord_z, {GW{1'b0}}};

    always_comb begin
        // turn the left half plane by a quarter so vectoring starts with x >= 0
        if (w_cx[DW-1]) begin
            if (!w_cy[DW-1]) begin
                n_s0_yaw.x   = w_cy;
                n_s0_yaw.y   = -w_cx;
                n_s0_yaw.acc = vtyp_pkg::DEG_90;
            end else begin
                n_s0_yaw.x   = -w_cy;
                n_s0_yaw.y   = w_cx;
                n_s0_yaw.acc = -vtyp_pkg::DEG_90;
            end
        end else begin
            n_s0_yaw.x   = w_cx;
            n_s0_yaw.y   = w_cy;
            n_s0_yaw.acc = '0;
        end
        // z runs on its magnitude only to pick up the CORDIC gain
        n_s0_z.x   = w_cz[DW-1] ? -w_cz : w_cz;
        n_s0_z.y   = '0;
        n_s0_z.acc = '0;
        n_s0_side.zero_xy = (i_in_data.coord_x == '0) && (i_in_data.coord_y == '0);
        n_s0_side.z_neg   = i_in_data.coord_z[CW-1];
        n_s0_side.z_pos   = !i_in_data.coord_z[CW-1] && (i_in_data.coord_z != '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r_s0_yaw <= n_s0_yaw;
            r_s0_z   <= n_s0_z;
        end
    end

    // side flags ride along with each item up to the output stage
    vtyp_pkg::t_side r_side [S_OUT];

    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r_side[0] <= n_s0_side;
        end
    end

    generate
        for (k = 1; k < S_OUT; k++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (w_ready[k]) begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    endgenerate

    // ---------------- first row: yaw and z gain ----------------
    vtyp_pkg::t_vec w_a_yaw [N+1];
    vtyp_pkg::t_vec w_a_z   [N+1];

    assign w_a_yaw[0] = r_s0_yaw;
    assign w_a_z[0]   = r_s0_z;

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_row_a
            vtyp_cell #(.SHIFT(i)) u_yaw (
                .i_clk (i_clk),
                .i_en  (w_ready[1+i]),
                .i_vec (w_a_yaw[i]),
                .o_vec (w_a_yaw[i+1])
            );
            vtyp_cell #(.SHIFT(i)) u_zg (
                .i_clk (i_clk),
                .i_en  (w_ready[1+i]),
                .i_vec (w_a_z[i]),
                .o_vec (w_a_z[i+1])
            );
        end
    endgenerate

    // ---------------- hand-over stage ----------------
    vtyp_pkg::t_vec            n_mid;
    vtyp_pkg::t_vec            r_mid;
    logic signed [ANG_W-1:0]   r_mid_yaw;
    logic signed [DW-1:0]      w_zg;

    assign w_zg = w_a_z[N].x;

    always_comb begin
        n_mid.x   = w_a_yaw[N].x;
        n_mid.y   = r_side[S_MID-1].z_neg ? -w_zg : w_zg;
        n_mid.acc = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[S_MID]) begin
            r_mid     <= n_mid;
            r_mid_yaw <= w_a_yaw[N].acc;
        end
    end

    // ---------------- second row: pitch ----------------
    vtyp_pkg::t_vec          w_b [N+1];
    logic signed [ANG_W-1:0] r_b_yaw [N];

    assign w_b[0] = r_mid;

    generate
        for (i = 0; i < N; i++) begin : g_row_b
            vtyp_cell #(.SHIFT(i)) u_pitch (
                .i_clk (i_clk),
                .i_en  (w_ready[S_MID+1+i]),
                .i_vec (w_b[i]),
                .o_vec (w_b[i+1])
            );
            if (i == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (w_ready[S_MID+1]) begin
                        r_b_yaw[0] <= r_mid_yaw;
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (w_ready[S_MID+1+i]) begin
                        r_b_yaw[i] <= r_b_yaw[i-1];
                    end
                end
            end
        end
    endgenerate

    // ---------------- output register ----------------
    vtyp_pkg::t_side     w_oside;
    vtyp_pkg::t_out_item n_out;
    vtyp_pkg::t_out_item r_out;

    assign w_oside = r_side[S_OUT-1];

    always_comb begin
        if (w_oside.zero_xy) begin
            // no horizontal part: straight up, else straight down
            n_out.yaw_deg   = '0;
            n_out.pitch_deg = w_oside.z_pos ? vtyp_pkg::DEG_90[vtyp_pkg::OUT_W-1:0]
                                            : vtyp_pkg::DEG_270[vtyp_pkg::OUT_W-1:0];
        end else begin
            n_out.yaw_deg   = vtyp_pkg::wrap_angle(r_b_yaw[N-1]);
            n_out.pitch_deg = vtyp_pkg::wrap_angle(w_b[N].acc);
        end
    end

    // hold the result while the output side stalls
    always_ff @(posedge i_clk) begin
        if (w_ready[S_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    // ---------------- assertions ----------------
    logic w_in_acc;
    logic w_out_acc;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.yaw_deg < vtyp_pkg::DEG_360[vtyp_pkg::OUT_W-1:0]) &&
                        (o_out_data.pitch_deg < vtyp_pkg::DEG_360[vtyp_pkg::OUT_W-1:0]))
        else $error("angle out of range");

    a_no_stall_when_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || !i_out_stall) |-> !o_in_stall)
        else $error("input stalled while output drains");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(w_valid) ==
             $past($countones(w_valid)) + int'($past(w_in_acc)) - int'($past(w_out_acc))))
        else $error("item lost or duplicated in pipeline");

    a_zero_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && w_valid[NSTAGE-1] && $past(w_ready[S_OUT]) && $past(w_oside.zero_xy)
         && $past(w_valid[S_OUT-1])) |-> (o_out_data.yaw_deg == '0))
        else $error("zero horizontal vector gave nonzero yaw");

endmodule

/* rtl/vtyp_link.sv */
module vtyp_link (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_ready_next,
    output logic o_valid,
    output logic o_ready
);

    logic r_valid;

    // take a new item whenever this slot is empty or drains this cycle
    assign o_ready = !r_valid || i_ready_next;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

endmodule

/* rtl/vtyp_cell.sv */
module vtyp_cell #(
    parameter int SHIFT = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  vtyp_pkg::t_vec  i_vec,
    output vtyp_pkg::t_vec  o_vec
);

    logic signed [vtyp_pkg::DW-1:0]    w_x;
    logic signed [vtyp_pkg::DW-1:0]    w_y;
    logic signed [vtyp_pkg::DW-1:0]    w_xs;
    logic signed [vtyp_pkg::DW-1:0]    w_ys;
    logic signed [vtyp_pkg::ANG_W-1:0] w_acc;
    logic signed [vtyp_pkg::ANG_W-1:0] w_ang;
    vtyp_pkg::t_vec                    n_vec;
    vtyp_pkg::t_vec                    r_vec;

    assign w_x   = i_vec.x;
    assign w_y   = i_vec.y;
    assign w_acc = i_vec.acc;
    assign w_xs  = w_x >>> SHIFT;
    assign w_ys  = w_y >>> SHIFT;
    assign w_ang = vtyp_pkg::atan_q16(5'(SHIFT));

    // rotate toward y = 0
    always_comb begin
        if (w_y[vtyp_pkg::DW-1]) begin
            n_vec.x   = w_x - w_ys;
            n_vec.y   = w_y + w_xs;
            n_vec.acc = w_acc - w_ang;
        end else begin
            n_vec.x   = w_x + w_ys;
            n_vec.y   = w_y - w_xs;
            n_vec.acc = w_acc + w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule
